[rtl/stb_pkg.sv]
package stb_pkg;

   // Screen geometry
   localparam int SCREEN_W = 1024;
   localparam int SCREEN_H = 768;

   // Field widths
   localparam int COORD_W  = 12;
   localparam int ORIGIN_W = 13;
   localparam int SCALE_W  = 24;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 20;
   localparam int COLOR_W  = 24;
   localparam int MARK_W   = 9;
   localparam int CSR_IDX_W = 4;

   // Texture geometry and fixed-point layout
   localparam int TEX_BITS  = 10;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = COORD_W + SCALE_W;

   // Opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_TEXEL = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_X     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_X       = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_Y       = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SCALE_X = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SCALE_Y = 4'd7;

   localparam logic [SCALE_W-1:0] SCALE_ONE = 24'd65536;

   typedef struct packed {
      logic [COORD_W-1:0]  start_x;
      logic [COORD_W-1:0]  start_y;
      logic [COORD_W-1:0]  end_x;
      logic [COORD_W-1:0]  end_y;
      logic [ORIGIN_W-1:0] origin_x;
      logic [ORIGIN_W-1:0] origin_y;
      logic [SCALE_W-1:0]  inv_scale_x;
      logic [SCALE_W-1:0]  inv_scale_y;
   } cfg_type;

   // Word handed from the walker to the sampler
   typedef struct packed {
      logic                fetch_valid;
      logic [COORD_W-1:0]  fetch_col;
      logic [COORD_W-1:0]  fetch_row;
      logic                write_valid;
      logic [COORD_W-1:0]  ux;
      logic [COORD_W-1:0]  uy;
      logic [COLOR_W-1:0]  color;
      logic                done;
   } mid_type;

endpackage

[rtl/stb_if.sv]
interface stb_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [stb_pkg::BYTE_W-1:0]  red;
   logic [stb_pkg::BYTE_W-1:0]  green;
   logic [stb_pkg::BYTE_W-1:0]  blue;
   logic [stb_pkg::BYTE_W-1:0]  alpha;

   modport source (output valid, op, red, green, blue, alpha, input ready);
   modport sink   (input valid, op, red, green, blue, alpha, output ready);
endinterface

interface stb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         fetch_valid;
   logic [stb_pkg::INDEX_W-1:0]  texel_index;
   logic                         write_valid;
   logic [stb_pkg::INDEX_W-1:0]  frame_address;
   logic [stb_pkg::COLOR_W-1:0]  frame_color;
   logic [stb_pkg::MARK_W-1:0]   mark_x;
   logic [stb_pkg::MARK_W-1:0]   mark_y;
   logic                         done_res;

   modport source (output valid, fetch_valid, texel_index, write_valid, frame_address,
                   frame_color, mark_x, mark_y, done_res, input ready);
   modport sink   (input valid, fetch_valid, texel_index, write_valid, frame_address,
                   frame_color, mark_x, mark_y, done_res, output ready);
endinterface

interface stb_csr_if;
   logic                           valid;
   logic                           ready;
   logic [stb_pkg::CSR_IDX_W-1:0]  index;
   logic [stb_pkg::SCALE_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/stb_walker.sv]
module stb_walker (
   input  logic              clock,
   input  logic              reset,
   input  stb_pkg::cfg_type  cfg,
   stb_req_if.sink           req_ch,
   output logic              mid_valid,
   output stb_pkg::mid_type  mid_word,
   input  logic              mid_ready
);

   localparam int CW = stb_pkg::COORD_W;
   localparam int OW = stb_pkg::ORIGIN_W;

   // Input register
   logic                        in_v_ff, in_v_in;
   logic                        in_op_ff;
   logic [stb_pkg::BYTE_W-1:0]  in_red_ff, in_green_ff, in_blue_ff, in_alpha_ff;

   // Walk state
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic          run_ff, run_in;

   // Handoff register
   logic              mid_v_ff, mid_v_in;
   stb_pkg::mid_type  mid_ff, res;

   logic          accept, take;
   logic [CW:0]   nc, nr;
   logic [OW:0]   sx, sy;
   logic          on_screen;
   logic [CW-1:0] ec, er;
   logic          emit;

   assign take         = in_v_ff & (~mid_v_ff | mid_ready);
   assign req_ch.ready = ~in_v_ff | take;
   assign accept       = req_ch.valid & req_ch.ready;
   assign mid_valid    = mid_v_ff;
   assign mid_word     = mid_ff;

   // Screen position of the current coordinate
   assign sx = {{2{cfg.origin_x[OW-1]}}, cfg.origin_x[OW-2:0]} + (OW+1)'(col_ff);
   assign sy = {{2{cfg.origin_y[OW-1]}}, cfg.origin_y[OW-2:0]} + (OW+1)'(row_ff);
   assign on_screen = ~sx[OW] & (sx[OW-1:0] < OW'(stb_pkg::SCREEN_W))
                    & ~sy[OW] & (sy[OW-1:0] < OW'(stb_pkg::SCREEN_H));

   assign nc = {1'b0, col_ff} + 1'b1;
   assign nr = {1'b0, row_ff} + 1'b1;

   // Work out the next walk state and the word for this item
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      run_in = run_ff;
      res    = '0;
      emit   = 1'b0;
      ec     = col_ff;
      er     = row_ff;
      if (in_op_ff == stb_pkg::OP_START) begin
         ec   = cfg.start_x;
         er   = cfg.start_y;
         emit = 1'b1;
      end else if (run_ff) begin
         if (in_alpha_ff != '0 && on_screen) begin
            res.write_valid = 1'b1;
            res.ux          = sx[CW-1:0];
            res.uy          = sy[CW-1:0];
            res.color       = {in_blue_ff, in_green_ff, in_red_ff};
         end
         if (nc >= {1'b0, cfg.end_x}) begin
            ec = cfg.start_x;
            if (nr >= {1'b0, cfg.end_y}) begin
               res.done = 1'b1;
               run_in   = 1'b0;
            end else begin
               er   = nr[CW-1:0];
               emit = 1'b1;
            end
         end else begin
            ec   = nc[CW-1:0];
            emit = 1'b1;
         end
      end
      // Issue the next fetch or close the walk
      if (emit) begin
         if (ec < cfg.end_x && er < cfg.end_y) begin
            res.fetch_valid = 1'b1;
            res.fetch_col   = ec;
            res.fetch_row   = er;
            run_in          = 1'b1;
         end else begin
            res.done = 1'b1;
            run_in   = 1'b0;
         end
      end
      if (in_op_ff == stb_pkg::OP_START || run_ff) begin
         col_in = ec;
         row_in = er;
      end
   end

   always_comb begin
      in_v_in = in_v_ff;
      if (accept) begin
         in_v_in = 1'b1;
      end else if (take) begin
         in_v_in = 1'b0;
      end
      mid_v_in = mid_v_ff;
      if (take) begin
         mid_v_in = 1'b1;
      end else if (mid_ready) begin
         mid_v_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         mid_v_ff <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
         run_ff   <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         mid_v_ff <= mid_v_in;
         if (take) begin
            col_ff <= col_in;
            row_ff <= row_in;
            run_ff <= run_in;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff    <= req_ch.op;
         in_red_ff   <= req_ch.red;
         in_green_ff <= req_ch.green;
         in_blue_ff  <= req_ch.blue;
         in_alpha_ff <= req_ch.alpha;
      end
      if (take) begin
         mid_ff <= res;
      end
   end

endmodule

[rtl/stb_sampler.sv]
module stb_sampler (
   input  logic              clock,
   input  logic              reset,
   input  stb_pkg::cfg_type  cfg,
   input  logic              mid_valid,
   input  stb_pkg::mid_type  mid_word,
   output logic              mid_ready,
   stb_rsp_if.source         rsp_ch
);

   localparam int PW = stb_pkg::PROD_W;
   localparam int FB = stb_pkg::FRAC_BITS;
   localparam int TB = stb_pkg::TEX_BITS;
   localparam int IW = stb_pkg::INDEX_W;

   logic           out_v_ff, out_v_in;
   logic           take;
   logic [PW-1:0]  px, qy, qy_up;
   logic [TB-1:0]  tc, tr;
   logic [IW-1:0]  texel, faddr;

   logic                         fetch_ff, write_ff, done_ff;
   logic [IW-1:0]                texel_ff, faddr_ff;
   logic [stb_pkg::COLOR_W-1:0]  color_ff;
   logic [stb_pkg::MARK_W-1:0]   mark_x_ff, mark_y_ff;

   assign take      = mid_valid & (~out_v_ff | rsp_ch.ready);
   assign mid_ready = ~out_v_ff | rsp_ch.ready;

   // Scale coordinates into texture space; rows round up, then flip
   assign px    = PW'(mid_word.fetch_col) * PW'(cfg.inv_scale_x);
   assign qy    = PW'(mid_word.fetch_row) * PW'(cfg.inv_scale_y);
   assign qy_up = qy + PW'((1 << FB) - 1);
   assign tc    = px[FB +: TB];
   assign tr    = ~qy_up[FB +: TB];
   assign texel = mid_word.fetch_valid ? {tr, tc} : '0;

   // Framebuffer address, wrapped to the address width
   assign faddr = IW'(mid_word.uy) * IW'(stb_pkg::SCREEN_W) + IW'(mid_word.ux);

   always_comb begin
      out_v_in = out_v_ff;
      if (take) begin
         out_v_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (take) begin
         fetch_ff  <= mid_word.fetch_valid;
         texel_ff  <= texel;
         write_ff  <= mid_word.write_valid;
         faddr_ff  <= mid_word.write_valid ? faddr : '0;
         color_ff  <= mid_word.color;
         mark_x_ff <= stb_pkg::MARK_W'(mid_word.ux >> 1);
         mark_y_ff <= stb_pkg::MARK_W'(mid_word.uy >> 1);
         done_ff   <= mid_word.done;
      end
   end

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.fetch_valid   = fetch_ff;
   assign rsp_ch.texel_index   = texel_ff;
   assign rsp_ch.write_valid   = write_ff;
   assign rsp_ch.frame_address = faddr_ff;
   assign rsp_ch.frame_color   = color_ff;
   assign rsp_ch.mark_x        = mark_x_ff;
   assign rsp_ch.mark_y        = mark_y_ff;
   assign rsp_ch.done_res      = done_ff;

endmodule

[rtl/scaled_texture_blit.sv]
// Scaled texture blitter: send a start word (op 0) to begin walking the
// configured rectangle, then return one texel word (op 1) for every fetch the
// block asks for. Each result word carries the next texel index to fetch, a
// framebuffer write for an opaque on-screen pixel, or a done flag (a write may
// come with a fetch or a done flag), or is all zero for a texel sent while no
// walk runs. One word is accepted every cycle while the result side does not
// hold it back; its result passes through the input register, the walker
// register and the result register; the walk counters step at most once per
// word in the walker stage. Registers may be written at any time but should
// only be changed while no walk is in flight.
module scaled_texture_blit (
   input  logic       clock,
   input  logic       reset,
   stb_req_if.sink    req_ch,
   stb_rsp_if.source  rsp_ch,
   stb_csr_if.sink    csr_ch
);

   stb_pkg::cfg_type  cfg_ff, cfg_in;
   logic              csr_write;
   logic              mid_valid, mid_ready;
   stb_pkg::mid_type  mid_word;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid;

   // Decode register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_ch.index)
            stb_pkg::CSR_START_X:     cfg_in.start_x     = csr_ch.data[stb_pkg::COORD_W-1:0];
            stb_pkg::CSR_START_Y:     cfg_in.start_y     = csr_ch.data[stb_pkg::COORD_W-1:0];
            stb_pkg::CSR_END_X:       cfg_in.end_x       = csr_ch.data[stb_pkg::COORD_W-1:0];
            stb_pkg::CSR_END_Y:       cfg_in.end_y       = csr_ch.data[stb_pkg::COORD_W-1:0];
            stb_pkg::CSR_ORIGIN_X:    cfg_in.origin_x    = csr_ch.data[stb_pkg::ORIGIN_W-1:0];
            stb_pkg::CSR_ORIGIN_Y:    cfg_in.origin_y    = csr_ch.data[stb_pkg::ORIGIN_W-1:0];
            stb_pkg::CSR_INV_SCALE_X: cfg_in.inv_scale_x = csr_ch.data;
            stb_pkg::CSR_INV_SCALE_Y: cfg_in.inv_scale_y = csr_ch.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{start_x: '0, start_y: '0, end_x: '0, end_y: '0,
                     origin_x: '0, origin_y: '0,
                     inv_scale_x: stb_pkg::SCALE_ONE,
                     inv_scale_y: stb_pkg::SCALE_ONE};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stb_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_ch    (req_ch),
      .mid_valid (mid_valid),
      .mid_word  (mid_word),
      .mid_ready (mid_ready)
   );

   stb_sampler u_sampler (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_valid (mid_valid),
      .mid_word  (mid_word),
      .mid_ready (mid_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

[test/scaled_texture_blit_test.sv]
module scaled_texture_blit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import stb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int WORD_TARGET = 1150;
   localparam int QUIET_LO    = 3000;
   localparam int QUIET_HI    = 6000;
   localparam int SETTLE      = 20;
   localparam int FEED_MAX    = 8;

   typedef struct packed {
      logic              op;
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] alpha;
   } texel_word_type;

   typedef struct packed {
      logic               fetch_valid;
      logic [INDEX_W-1:0] texel_index;
      logic               write_valid;
      logic [INDEX_W-1:0] frame_address;
      logic [COLOR_W-1:0] frame_color;
      logic [MARK_W-1:0]  mark_x;
      logic [MARK_W-1:0]  mark_y;
      logic               done_res;
   } blit_word_type;

   logic clock;
   logic reset;

   stb_req_if req_bus ();
   stb_rsp_if rsp_bus ();
   stb_csr_if csr_bus ();

   scaled_texture_blit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Walker copy: registers and counters as the block should hold them
   cfg_type            cfg;
   logic [COORD_W-1:0] walk_col;
   logic [COORD_W-1:0] walk_row;
   logic               walk_running;

   texel_word_type pending_words[$];
   blit_word_type  expected_words[$];
   texel_word_type held_word;
   int             words_queued;
   int             cycle_count;
   int             error_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hold back at random, except within one quiet window
   function automatic bit stall_pick();
      if (cycle_count >= QUIET_LO && cycle_count < QUIET_HI) return 1'b0;
      return $urandom_range(0, 99) < 31;
   endfunction

   // Nearest-neighbour texel with vertical flip; floor on the column, ceiling and true modulo on the row
   function automatic logic [INDEX_W-1:0] texel_at(logic [COORD_W-1:0] cx,
                                                   logic [COORD_W-1:0] cy);
      logic [35:0]         p;
      logic [39:0]         q;
      logic [TEX_BITS-1:0] tc;
      logic [TEX_BITS-1:0] tr;
      p  = 36'(cx) * 36'(cfg.inv_scale_x);
      tc = p[FRAC_BITS +: TEX_BITS];
      q  = (40'(cy) * 40'(cfg.inv_scale_y) + 40'd65535) >> FRAC_BITS;
      tr = 10'd1023 - q[TEX_BITS-1:0];
      return {tr, tc};
   endfunction

   // Ask for the current texel, or end the walk when out of the rectangle
   function automatic blit_word_type fetch_or_finish(blit_word_type r);
      if (walk_col < cfg.end_x && walk_row < cfg.end_y) begin
         r.fetch_valid = 1'b1;
         r.texel_index = texel_at(walk_col, walk_row);
      end else begin
         walk_running = 1'b0;
         r.done_res   = 1'b1;
      end
      return r;
   endfunction

   // Advance the walker copy by one accepted word and give its result
   function automatic blit_word_type blit_step(texel_word_type w);
      blit_word_type      r;
      int                 sx;
      int                 sy;
      logic [COORD_W:0]   nc;
      logic [COORD_W:0]   nr;
      r = '0;
      if (w.op == OP_START) begin
         walk_col     = cfg.start_x;
         walk_row     = cfg.start_y;
         walk_running = 1'b1;
         return fetch_or_finish(r);
      end
      if (!walk_running) return r;
      if (w.alpha != '0) begin
         sx = int'($signed(cfg.origin_x)) + int'(walk_col);
         sy = int'($signed(cfg.origin_y)) + int'(walk_row);
         if (sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H) begin
            r.write_valid   = 1'b1;
            r.frame_address = INDEX_W'(sy * SCREEN_W + sx);
            r.frame_color   = {w.blue, w.green, w.red};
            r.mark_x        = MARK_W'(sx >> 1);
            r.mark_y        = MARK_W'(sy >> 1);
         end
      end
      nc = {1'b0, walk_col} + 1'b1;
      if (nc >= {1'b0, cfg.end_x}) begin
         nr       = {1'b0, walk_row} + 1'b1;
         walk_col = cfg.start_x;
         if (nr >= {1'b0, cfg.end_y}) begin
            walk_running = 1'b0;
            r.done_res   = 1'b1;
            return r;
         end
         walk_row = nr[COORD_W-1:0];
      end else begin
         walk_col = nc[COORD_W-1:0];
      end
      return fetch_or_finish(r);
   endfunction

   function automatic void push_word(logic op, logic [BYTE_W-1:0] a, logic [23:0] rgb);
      pending_words.push_back('{op: op, red: rgb[7:0], green: rgb[15:8],
                                blue: rgb[23:16], alpha: a});
      words_queued++;
   endfunction

   function automatic void push_texel();
      push_word(OP_TEXEL, ($urandom_range(0, 4) == 0) ? 8'd0 : BYTE_W'($urandom()),
                24'($urandom()));
   endfunction

   // Wait until every queued word has gone in and its result has come out
   task automatic drain();
      while (pending_words.size() != 0 || req_bus.valid || expected_words.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SCALE_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_START_X:     cfg.start_x     = value[COORD_W-1:0];
         CSR_START_Y:     cfg.start_y     = value[COORD_W-1:0];
         CSR_END_X:       cfg.end_x       = value[COORD_W-1:0];
         CSR_END_Y:       cfg.end_y       = value[COORD_W-1:0];
         CSR_ORIGIN_X:    cfg.origin_x    = value[ORIGIN_W-1:0];
         CSR_ORIGIN_Y:    cfg.origin_y    = value[ORIGIN_W-1:0];
         CSR_INV_SCALE_X: cfg.inv_scale_x = value;
         CSR_INV_SCALE_Y: cfg.inv_scale_y = value;
         default: ;
      endcase
   endtask

   // Feed a few texels to end the walk in flight; close a long walk by
   // shrinking the rectangle so that the next texel ends it
   task automatic finish_walk();
      int fed;
      fed = 0;
      drain();
      while (walk_running && fed < FEED_MAX) begin
         push_texel();
         drain();
         fed++;
      end
      if (walk_running) begin
         write_reg(CSR_END_X, '0);
         write_reg(CSR_END_Y, '0);
         push_texel();
         drain();
      end
   endtask

   // Close the walk in flight, then load a whole new setting
   task automatic set_cfg(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                          input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                          input logic [ORIGIN_W-1:0] ox, input logic [ORIGIN_W-1:0] oy,
                          input logic [SCALE_W-1:0] kx, input logic [SCALE_W-1:0] ky);
      finish_walk();
      write_reg(CSR_START_X, SCALE_W'(sx));
      write_reg(CSR_START_Y, SCALE_W'(sy));
      write_reg(CSR_END_X, SCALE_W'(ex));
      write_reg(CSR_END_Y, SCALE_W'(ey));
      write_reg(CSR_ORIGIN_X, SCALE_W'(ox));
      write_reg(CSR_ORIGIN_Y, SCALE_W'(oy));
      write_reg(CSR_INV_SCALE_X, kx);
      write_reg(CSR_INV_SCALE_Y, ky);
   endtask

   function automatic logic [SCALE_W-1:0] pick_scale();
      case ($urandom_range(0, 3))
         0:       return SCALE_W'($urandom());
         1:       return SCALE_ONE;
         2:       return SCALE_W'($urandom_range(0, 24'h03FFFF));
         default: return SCALE_W'($urandom_range(24'h008000, 24'h020000));
      endcase
   endfunction

   // Driver: present pending words, predict each one as it is taken
   always @(posedge clock) begin : driver
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_words.push_back(blit_step(held_word));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_words.size() != 0 && !stall_pick()) begin
               held_word      = pending_words.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.op    <= held_word.op;
               req_bus.red   <= held_word.red;
               req_bus.green <= held_word.green;
               req_bus.blue  <= held_word.blue;
               req_bus.alpha <= held_word.alpha;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin : monitor
      blit_word_type got;
      blit_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{fetch_valid: rsp_bus.fetch_valid, texel_index: rsp_bus.texel_index,
                    write_valid: rsp_bus.write_valid, frame_address: rsp_bus.frame_address,
                    frame_color: rsp_bus.frame_color, mark_x: rsp_bus.mark_x,
                    mark_y: rsp_bus.mark_y, done_res: rsp_bus.done_res};
            if (expected_words.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result word: fv=%0d ti=%h wv=%0d fa=%h fc=%h",
                           got.fetch_valid, got.texel_index, got.write_valid,
                           got.frame_address, got.frame_color);
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display({"mismatch expected: fv=%0d ti=%h wv=%0d fa=%h fc=%h",
                               " mx=%0d my=%0d dn=%0d"},
                              want.fetch_valid, want.texel_index, want.write_valid,
                              want.frame_address, want.frame_color, want.mark_x,
                              want.mark_y, want.done_res);
                     $display({"         actual:   fv=%0d ti=%h wv=%0d fa=%h fc=%h",
                               " mx=%0d my=%0d dn=%0d"},
                              got.fetch_valid, got.texel_index, got.write_valid,
                              got.frame_address, got.frame_color, got.mark_x,
                              got.mark_y, got.done_res);
                  end
               end
            end
         end
         rsp_bus.ready <= !stall_pick();
      end
   end

   // Watchdog
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic [COORD_W-1:0]  sx;
      logic [COORD_W-1:0]  sy;
      logic [COORD_W-1:0]  ex;
      logic [COORD_W-1:0]  ey;
      logic [ORIGIN_W-1:0] ox;
      logic [ORIGIN_W-1:0] oy;
      int                  span;
      int                  n;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op    = OP_START;
      req_bus.red   = '0;
      req_bus.green = '0;
      req_bus.blue  = '0;
      req_bus.alpha = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_START_X;
      csr_bus.data  = '0;
      cfg           = '{start_x: '0, start_y: '0, end_x: '0, end_y: '0,
                        origin_x: '0, origin_y: '0,
                        inv_scale_x: SCALE_ONE, inv_scale_y: SCALE_ONE};
      walk_col      = '0;
      walk_row      = '0;
      walk_running  = 1'b0;
      words_queued  = 0;
      cycle_count   = 0;
      error_count   = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset setting: empty rectangle answers done, texel while idle gives an all-zero word
      push_word(OP_START, 8'hFF, 24'hFFFFFF);
      push_word(OP_TEXEL, 8'hFF, 24'hFFFFFF);

      // Small walk: transparent, opaque, restart mid-walk, texel after the end
      set_cfg(12'd0, 12'd0, 12'd3, 12'd2, '0, '0, SCALE_ONE, SCALE_ONE);
      push_word(OP_START, 8'h00, 24'h000000);
      push_word(OP_TEXEL, 8'h00, 24'hFFFFFF);
      push_word(OP_TEXEL, 8'hFF, 24'h0000FF);
      push_word(OP_TEXEL, 8'h01, 24'h00FF00);
      push_word(OP_START, 8'hFF, 24'hFFFFFF);
      push_word(OP_TEXEL, 8'h80, 24'hFF0000);
      repeat (5) push_word(OP_TEXEL, 8'hFF, 24'h5AA5C3);
      push_word(OP_TEXEL, 8'hFF, 24'h123456);

      // Right and bottom screen edges, widest and zero scales
      set_cfg(12'd1022, 12'd766, 12'd1025, 12'd769, '0, '0, 24'hFFFFFF, 24'h000000);
      push_word(OP_START, 8'h00, 24'h000000);
      repeat (9) push_word(OP_TEXEL, 8'hFF, 24'hFFFFFF);

      // Highest coordinates pulled back to the top-left corner
      set_cfg(12'd4094, 12'd4093, 12'd4095, 12'd4095, -13'sd4094, -13'sd4094,
              24'h000001, 24'hFFFFFF);
      push_word(OP_START, 8'h00, 24'h000000);
      repeat (2) push_word(OP_TEXEL, 8'hFF, 24'hA5A5A5);

      // Most negative origin keeps every pixel off screen
      set_cfg(12'd0, 12'd0, 12'd2, 12'd1, -13'sd4096, -13'sd4096, SCALE_ONE, SCALE_ONE);
      push_word(OP_START, 8'h00, 24'h000000);
      repeat (2) push_word(OP_TEXEL, 8'hFF, 24'h00FFFF);

      // Empty in one direction only
      set_cfg(12'd5, 12'd0, 12'd5, 12'd4, 13'sd4095, 13'sd4095, SCALE_ONE, SCALE_ONE);
      push_word(OP_START, 8'h00, 24'h000000);
      set_cfg(12'd0, 12'd9, 12'd4, 12'd3, '0, '0, SCALE_ONE, SCALE_ONE);
      push_word(OP_START, 8'h00, 24'h000000);

      // Random settings and walks, with restarts and stray words mixed in
      while (words_queued < WORD_TARGET) begin
         sx   = COORD_W'($urandom());
         sy   = COORD_W'($urandom());
         span = $urandom_range(0, 6);
         ex   = ($urandom_range(0, 15) == 0) ? COORD_W'($urandom())
                                             : COORD_W'((int'(sx) + span > 4095) ? 4095
                                                                                 : sx + span);
         span = $urandom_range(0, 5);
         ey   = ($urandom_range(0, 15) == 0) ? COORD_W'($urandom())
                                             : COORD_W'((int'(sy) + span > 4095) ? 4095
                                                                                 : sy + span);
         if ($urandom_range(0, 1) == 0) begin
            ox = ORIGIN_W'($urandom());
            oy = ORIGIN_W'($urandom());
         end else begin
            ox = ORIGIN_W'($urandom_range(0, 1031) - 4 - int'(sx));
            oy = ORIGIN_W'($urandom_range(0, 775) - 4 - int'(sy));
         end
         set_cfg(sx, sy, ex, ey, ox, oy, pick_scale(), pick_scale());
         if ($urandom_range(0, 9) == 0) push_texel();
         push_word(OP_START, BYTE_W'($urandom()), 24'($urandom()));
         n = (int'(ex) > int'(sx) && int'(ey) > int'(sy))
             ? (int'(ex) - int'(sx)) * (int'(ey) - int'(sy)) : 1;
         if (n > 48) n = 48;
         n = n + $urandom_range(0, 2);
         repeat (n) begin
            if ($urandom_range(0, 99) < 5)
               push_word(OP_START, BYTE_W'($urandom()), 24'($urandom()));
            else
               push_texel();
         end
      end

      // Let everything settle, then decide
      finish_walk();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[files.f]
rtl/stb_pkg.sv
rtl/stb_if.sv
rtl/stb_walker.sv
rtl/stb_sampler.sv
rtl/scaled_texture_blit.sv
test/scaled_texture_blit_test.sv
